/* rtl/core/dedup_fifo_move_to_back_assert.svh */
// Assertion macros shared by the deduplicating FIFO RTL.
`ifndef DEDUP_FIFO_MOVE_TO_BACK_ASSERT_SVH
`define DEDUP_FIFO_MOVE_TO_BACK_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define DFMB_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("dfmb invariant violated");
// Checks that a trigger in one cycle implies a consequence in the next cycle.
`define DFMB_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
        else $error("dfmb next-cycle check failed");
`else
`define DFMB_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DFMB_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif

`endif

/* rtl/core/dfmb_pkg.sv */
// Types, constants and status codes of the deduplicating FIFO.
package dfmb_pkg;

    localparam int DFMB_CAPACITY = 16;
    localparam int DATA_W        = 8;
    localparam int OCC_W         = 5;
    localparam int STATUS_W      = 2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_GET_EMPTY = 2'd1,
        STATUS_PUT_FULL  = 2'd2
    } status_t;

    // Operation codes.
    typedef enum logic {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } op_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic              step;
        logic              get;
        logic              found;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

    // Link from a cell to its tail-side neighbor.
    typedef struct packed {
        logic valid;
        logic match;
    } fwd_link_t;

    // Link from a cell to its head-side neighbor.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
    } back_link_t;

endpackage

/* rtl/core/dfmb_cell.sv */
// One queue cell: holds an entry, compares it, and shifts toward the head.
module dfmb_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dfmb_pkg::cell_ctrl_t ctrl,
    input  dfmb_pkg::fwd_link_t  fwd_in,
    output dfmb_pkg::fwd_link_t  fwd_out,
    input  dfmb_pkg::back_link_t back_in,
    output dfmb_pkg::back_link_t back_out
);
    import dfmb_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              my_match;

    // Compare against the put value and extend the match chain.
    assign my_match      = valid_reg && (value_reg == ctrl.value);
    assign fwd_out.valid = valid_reg;
    assign fwd_out.match = fwd_in.match || my_match;
    assign back_out.valid = valid_reg;
    assign back_out.value = value_reg;

    // Next entry: shift in from the tail side, take the put value, or hold.
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.step) begin
            if (ctrl.get) begin
                valid_next = back_in.valid;
                value_next = back_in.value;
            end else if (ctrl.found) begin
                // Cells from the old copy onward close the gap; the tail cell
                // receives the new value.
                if (fwd_out.match && valid_reg) begin
                    if (back_in.valid) begin
                        value_next = back_in.value;
                    end else begin
                        value_next = ctrl.value;
                    end
                end
            end else if (fwd_in.valid && !valid_reg) begin
                valid_next = 1'b1;
                value_next = ctrl.value;
            end
        end
    end

    // Valid bit is control state; the value needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

/* rtl/core/dedup_fifo_move_to_back.sv */
// Top level of the deduplicating FIFO that moves a repeated value to the tail.
//
// Input channel s_*: each transfer carries s_op (put or get) and s_item_value.
// Result channel m_*: exactly one result transfer follows each input transfer,
// carrying the popped value, a status, the duplicate flag, the occupancy and
// the empty flag as they stand after that item.
// The queue is a row of CAPACITY cells, head in cell 0. Every cell compares
// its entry with the put value at once and a prefix-OR chain runs along the
// row, and the result of a put or get is valid in the cycle after the input
// transfer. One item can be taken every cycle while m_ready is high.
// The ripple of the match chain through all cells sets the clock limit.
// A single output register holds the result; while it is full and m_ready is
// low, s_ready is low, so a stalled receiver stalls the input side without
// losing anything.
// Reset (aresetn low, synchronous) empties the queue and the output register.
// A put of a new value into a full queue is refused with status 2.
`include "dedup_fifo_move_to_back_assert.svh"

module dedup_fifo_move_to_back #(
    parameter int CAPACITY = dfmb_pkg::DFMB_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [dfmb_pkg::DATA_W-1:0]   s_item_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dfmb_pkg::DATA_W-1:0]   m_out_value,
    output logic [dfmb_pkg::STATUS_W-1:0] m_status,
    output logic                          m_was_duplicate,
    output logic [dfmb_pkg::OCC_W-1:0]    m_occupancy,
    output logic                          m_is_empty
);
    import dfmb_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctrl_t  ctrl;
    fwd_link_t   fwd   [CAPACITY+1];
    back_link_t  back  [CAPACITY+1];
    logic [CAPACITY-1:0] valid_vec;

    logic             accept;
    logic             found;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;

    logic              m_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [DATA_W-1:0] out_value_next;
    status_t           status_reg;
    status_t           status_next;
    logic              dup_reg;
    logic              dup_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic              is_empty_reg;
    logic              is_empty_next;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    // Handshake: one output register, refilled in the cycle it drains.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Ends of the chain: head side sees a valid, unmatched neighbor.
    assign fwd[0].valid       = 1'b1;
    assign fwd[0].match       = 1'b0;
    assign back[CAPACITY]     = '0;
    assign found              = fwd[CAPACITY].match;

    assign ctrl.step  = accept;
    assign ctrl.get   = (s_op == OP_GET);
    assign ctrl.found = found;
    assign ctrl.value = s_item_value;

    // The row of cells.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        dfmb_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .fwd_in  (fwd[i]),
            .fwd_out (fwd[i+1]),
            .back_in (back[i+1]),
            .back_out(back[i])
        );
        assign valid_vec[i] = fwd[i+1].valid;
    end

    assign full  = (fill_count_reg == CNT_W'(CAPACITY));
    assign empty = (fill_count_reg == '0);

    // Result of the item at the input and the new occupancy.
    always_comb begin
        out_value_next  = '0;
        status_next     = STATUS_OK;
        dup_next        = 1'b0;
        fill_count_next = fill_count_reg;
        if (s_op == OP_GET) begin
            if (empty) begin
                status_next = STATUS_GET_EMPTY;
            end else begin
                out_value_next  = back[0].value;
                fill_count_next = fill_count_reg - CNT_W'(1);
            end
        end else if (found) begin
            dup_next = 1'b1;
        end else if (full) begin
            status_next = STATUS_PUT_FULL;
        end else begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        occ_wide      = {{OCC_W{1'b0}}, fill_count_next};
        occ_next      = occ_wide[OCC_W-1:0];
        is_empty_next = (fill_count_next == '0);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            fill_count_reg <= '0;
        end else begin
            if (accept) begin
                m_valid_reg    <= 1'b1;
                fill_count_reg <= fill_count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_value_reg <= out_value_next;
            status_reg    <= status_next;
            dup_reg       <= dup_next;
            occ_reg       <= occ_next;
            is_empty_reg  <= is_empty_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_value     = out_value_reg;
    assign m_status        = status_reg;
    assign m_was_duplicate = dup_reg;
    assign m_occupancy     = occ_reg;
    assign m_is_empty      = is_empty_reg;

    // The valid bits of the cells always form the occupancy count.
    `DFMB_ASSERT_ALWAYS(a_valid_count, aclk, aresetn, ($countones(valid_vec) == fill_count_reg))
    // The count never exceeds the capacity.
    `DFMB_ASSERT_ALWAYS(a_count_range, aclk, aresetn, (fill_count_reg <= CNT_W'(CAPACITY)))
    // A get on an empty queue reports the empty status.
    `DFMB_ASSERT_NEXT(a_get_empty, aclk, aresetn, (accept && s_op == OP_GET && empty), (m_status == STATUS_GET_EMPTY))
    // A duplicate put leaves the occupancy unchanged.
    `DFMB_ASSERT_NEXT(a_dup_count, aclk, aresetn, (accept && s_op == OP_PUT && found), (fill_count_reg == $past(fill_count_reg)))

endmodule
